// File: hdl/char_lcd_value_readout_unit_assert.svh
// assertion macros used by the back end of the lcd readout unit
`ifndef CHAR_LCD_VALUE_READOUT_UNIT_ASSERT_SVH
`define CHAR_LCD_VALUE_READOUT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define CLVR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clvr same-cycle check failed");
// next-cycle implication, checked out of reset
`define CLVR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clvr next-cycle check failed");
`else
`define CLVR_ASSERT_IMP(label, ante, cons)
`define CLVR_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: hdl/clvr_pkg.sv
// shared types, codes and constants of the lcd readout unit
package clvr_pkg;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_SHOW = 1'b1;

  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  localparam int THR_W = 13;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 13'd2000;

  localparam int ADDR_W = 3;
  localparam logic REG_THRESHOLD = 1'b0;  // word index bit paddr[2]

  localparam int QUEUE_DEPTH = 2;

  localparam int POS_W = 6;
  localparam logic [POS_W-1:0] INIT_LAST = 6'd11;
  localparam logic [POS_W-1:0] SHOW_LAST = 6'd33;

  localparam logic [11:0] STEP_THOU = 12'd1000;
  localparam logic [9:0]  STEP_HUND = 10'd100;
  localparam logic [6:0]  STEP_TEN  = 7'd10;

  typedef struct packed {
    logic       cmd;
    logic       led_on;
    logic [3:0] d_thou;
    logic [3:0] d_hund;
    logic [3:0] d_tens;
    logic [3:0] d_ones;
  } desc_t;

endpackage

// File: hdl/clvr_front.sv
// front end: accepts requests, compares threshold and splits the sample into digits
module clvr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [11:0]                 in_sample,
  input  logic [clvr_pkg::THR_W-1:0]  threshold,
  output logic                        push_valid,
  input  logic                        push_ready,
  output clvr_pkg::desc_t             push_desc
);

  logic       s1_v_r, s1_cmd_r, s1_on_r;
  logic [2:0] s1_thou_r;
  logic [9:0] s1_rem_r;
  logic       s2_v_r, s2_cmd_r, s2_on_r;
  logic [2:0] s2_thou_r;
  logic [3:0] s2_hund_r;
  logic [6:0] s2_rem_r;

  logic       s1_adv, s2_adv;
  logic [2:0] thou_c;
  logic [9:0] rem1_c;
  logic [3:0] hund_c;
  logic [6:0] rem2_c;
  logic [3:0] tens_c;
  logic [3:0] ones_c;

  assign s2_adv   = s2_v_r && push_ready;
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;

  // thousands digit from four parallel compares
  always_comb begin
    thou_c = '0;
    for (int k = 1; k <= 4; k++) begin
      if (in_sample >= 12'(k * 1000)) thou_c = 3'(k);
    end
    rem1_c = 10'(in_sample - 12'(thou_c) * clvr_pkg::STEP_THOU);
  end

  always_comb begin
    hund_c = '0;
    for (int k = 1; k <= 9; k++) begin
      if (s1_rem_r >= 10'(k * 100)) hund_c = 4'(k);
    end
    rem2_c = 7'(s1_rem_r - 10'(hund_c) * clvr_pkg::STEP_HUND);
  end

  always_comb begin
    tens_c = '0;
    for (int k = 1; k <= 9; k++) begin
      if (s2_rem_r >= 7'(k * 10)) tens_c = 4'(k);
    end
    ones_c = 4'(s2_rem_r - 7'(tens_c) * clvr_pkg::STEP_TEN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (in_ready) s1_v_r <= in_valid;
      if (!s2_v_r || s2_adv) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_on_r   <= ({1'b0, in_sample} < threshold);
      s1_thou_r <= thou_c;
      s1_rem_r  <= rem1_c;
    end
    if (s1_adv) begin
      s2_cmd_r  <= s1_cmd_r;
      s2_on_r   <= s1_on_r;
      s2_thou_r <= s1_thou_r;
      s2_hund_r <= hund_c;
      s2_rem_r  <= rem2_c;
    end
  end

  assign push_valid       = s2_v_r;
  assign push_desc.cmd    = s2_cmd_r;
  assign push_desc.led_on = s2_on_r;
  assign push_desc.d_thou = {1'b0, s2_thou_r};
  assign push_desc.d_hund = s2_hund_r;
  assign push_desc.d_tens = tens_c;
  assign push_desc.d_ones = ones_c;

endmodule

// File: hdl/clvr_queue.sv
// short request queue between front and back
module clvr_queue #(
  parameter int DEPTH = clvr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  clvr_pkg::desc_t push_desc,
  output logic            pop_valid,
  input  logic            pop_ready,
  output clvr_pkg::desc_t pop_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clvr_pkg::desc_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_desc   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

// File: hdl/clvr_back.sv
// back end: walks one request and emits its nibble writes through an output register
module clvr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  clvr_pkg::desc_t pop_desc,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_register_select,
  output logic [3:0]      out_nibble,
  output logic            out_last
);

  `include "char_lcd_value_readout_unit_assert.svh"

  logic                          active_r;
  logic [clvr_pkg::POS_W-1:0]    pos_r, pos_nxt;
  clvr_pkg::desc_t               desc_r;
  logic                          out_valid_r, out_rs_r, out_last_r;
  logic [3:0]                    out_nib_r;

  logic       out_load, is_last, pop;
  logic       rs_c;
  logic [7:0] byte_c;
  logic [3:0] nib_c;

  assign out_load = active_r && (!out_valid_r || out_ready);
  assign is_last  = (pos_r == ((desc_r.cmd == clvr_pkg::CMD_INIT) ?
                               clvr_pkg::INIT_LAST : clvr_pkg::SHOW_LAST));
  assign pop       = pop_valid && (!active_r || (out_load && is_last));
  assign pop_ready = !active_r || (out_load && is_last);
  assign pos_nxt   = is_last ? '0 : pos_r + 1'b1;

  // byte and register select for the current position
  always_comb begin
    rs_c   = clvr_pkg::RS_DATA;
    byte_c = 8'h00;
    if (desc_r.cmd == clvr_pkg::CMD_INIT) begin
      rs_c = clvr_pkg::RS_INSTR;
      unique case (pos_r)
        6'd0, 6'd1, 6'd2: byte_c = 8'h33;
        6'd3:             byte_c = 8'h22;
        6'd4, 6'd5:       byte_c = 8'h28;
        6'd6, 6'd7:       byte_c = 8'h0C;
        6'd8, 6'd9:       byte_c = 8'h06;
        default:          byte_c = 8'h01;
      endcase
    end else begin
      unique case (pos_r[5:1])
        5'd0:  begin rs_c = clvr_pkg::RS_INSTR; byte_c = 8'h80; end
        5'd1:  byte_c = 8'h41;
        5'd2:  byte_c = 8'h44;
        5'd3:  byte_c = 8'h43;
        5'd4:  byte_c = 8'h3D;
        5'd5:  byte_c = {4'h3, desc_r.d_thou};
        5'd6:  byte_c = {4'h3, desc_r.d_hund};
        5'd7:  byte_c = {4'h3, desc_r.d_tens};
        5'd8:  byte_c = {4'h3, desc_r.d_ones};
        5'd9:  begin rs_c = clvr_pkg::RS_INSTR; byte_c = 8'hC0; end
        5'd10: byte_c = 8'h4C;
        5'd11: byte_c = 8'h45;
        5'd12: byte_c = 8'h44;
        5'd13: byte_c = 8'h3D;
        5'd14: byte_c = 8'h4F;
        5'd15: byte_c = desc_r.led_on ? 8'h4E : 8'h46;
        default: byte_c = desc_r.led_on ? 8'h20 : 8'h46;
      endcase
    end
    nib_c = pos_r[0] ? byte_c[3:0] : byte_c[7:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
        if (is_last) active_r <= pop_valid;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        if (!active_r && pop_valid) begin
          active_r <= 1'b1;
          pos_r    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) desc_r <= pop_desc;
    if (out_load) begin
      out_rs_r   <= rs_c;
      out_nib_r  <= nib_c;
      out_last_r <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_register_select = out_rs_r;
  assign out_nibble          = out_nib_r;
  assign out_last            = out_last_r;

  `CLVR_ASSERT_IMP(a_pos_range, active_r, pos_r <= clvr_pkg::SHOW_LAST)
  `CLVR_ASSERT_IMP(a_init_range, active_r && desc_r.cmd == clvr_pkg::CMD_INIT,
                   pos_r <= clvr_pkg::INIT_LAST)
  `CLVR_ASSERT_NXT(a_mid_run, out_load && !is_last, active_r && pos_r != '0)

endmodule

// File: hdl/char_lcd_value_readout_unit.sv
// top level of the character lcd value readout unit
//
//  channel   payload                                     handshake
//  in        in_command, in_sample                       in_valid / in_ready
//  out       out_register_select, out_nibble, out_last   out_valid / out_ready
//  cfg       paddr, pwdata, prdata                       psel, penable, pwrite, pready high
//
// an init transaction gives 12 nibble writes, a show transaction 34, one per cycle unless out_ready stalls them
// the nibble sequencer in the back end sets the rate at which show samples are taken
// a transaction passes the digit pipeline registers s1 and s2 before it is pushed into the queue,
// and when the back end is idle its first nibble then passes the queue, desc_r and the output register
// back-to-back requests run without gaps: the next one is taken on the last nibble
// rst_n is synchronous; it empties the pipeline and queue and sets the threshold to 2000
// a stalled out channel fills the queue and the two front stages, then drops in_ready
module char_lcd_value_readout_unit #(
  parameter int QUEUE_DEPTH = clvr_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [11:0]                  in_sample,
  // nibble write channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_register_select,
  output logic [3:0]                   out_nibble,
  output logic                         out_last,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clvr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [clvr_pkg::THR_W-1:0] thr_r;
  logic                       cfg_wr;

  logic            push_valid, push_ready;
  clvr_pkg::desc_t push_desc;
  logic            pop_valid, pop_ready;
  clvr_pkg::desc_t pop_desc;

  // register port: single threshold register at word 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= clvr_pkg::THRESHOLD_RESET;
    end else if (cfg_wr && paddr[2] == clvr_pkg::REG_THRESHOLD) begin
      thr_r <= pwdata[clvr_pkg::THR_W-1:0];
    end
  end

  // reads of unmapped words return zero
  assign prdata = (paddr[2] == clvr_pkg::REG_THRESHOLD) ?
                  {{(32 - clvr_pkg::THR_W){1'b0}}, thr_r} : 32'd0;

  // front end: threshold compare and decimal split
  clvr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_sample  (in_sample),
    .threshold  (thr_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // decoupling queue
  clvr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  // back end: nibble sequencer with output register
  clvr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_desc            (pop_desc),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_last            (out_last)
  );

endmodule

// File: tb/testbench.sv
// self-checking testbench of the character lcd value readout unit
module testbench;

  // one nibble write on the lcd bus as the unit should present it
  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } lcd_write_t;

  // one request toward the unit
  typedef struct packed {
    logic        command;
    logic [11:0] sample;
  } lcd_request_t;

  localparam logic [clvr_pkg::ADDR_W-1:0] THRESHOLD_ADDR = {clvr_pkg::REG_THRESHOLD, 2'b00};
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 49;
  localparam int DRAIN_CYCLES     = 40;
  localparam int REPORT_LIMIT     = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = clvr_pkg::CMD_INIT;
  logic [11:0] in_sample = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_register_select;
  logic [3:0]  out_nibble;
  logic        out_last;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [clvr_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // shadow of the led threshold register, updated on the apb write edge
  logic [clvr_pkg::THR_W-1:0] led_threshold = clvr_pkg::THRESHOLD_RESET;

  lcd_request_t request_fifo[$];
  lcd_write_t   lcd_writes_due[$];

  // idle behavior of both channels, changed only between phases
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  int error_count = 0;
  int init_count = 0;
  int show_count = 0;
  int writes_checked = 0;
  int settings_used = 1;

  char_lcd_value_readout_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_last            (out_last),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // expected lcd traffic for one request
  // the run is gathered first so the final nibble can carry the last flag
  // ---------------------------------------------------------------------------
  function automatic void add_byte(ref lcd_write_t run[$], input logic rs,
                                   input logic [7:0] value);
    run.push_back('{rs: rs, nib: value[7:4], last: 1'b0});
    run.push_back('{rs: rs, nib: value[3:0], last: 1'b0});
  endfunction

  function automatic void add_text(ref lcd_write_t run[$], input string text);
    for (int i = 0; i < text.len(); i++) begin
      add_byte(run, clvr_pkg::RS_DATA, text[i]);
    end
  endfunction

  function automatic void predict_lcd_writes(input logic command, input logic [11:0] sample);
    lcd_write_t run[$];
    int value;
    value = sample;
    if (command == clvr_pkg::CMD_INIT) begin
      // wake-up nibbles stand alone, no low half follows them
      run.push_back('{rs: clvr_pkg::RS_INSTR, nib: 4'h3, last: 1'b0});
      run.push_back('{rs: clvr_pkg::RS_INSTR, nib: 4'h3, last: 1'b0});
      run.push_back('{rs: clvr_pkg::RS_INSTR, nib: 4'h3, last: 1'b0});
      run.push_back('{rs: clvr_pkg::RS_INSTR, nib: 4'h2, last: 1'b0});
      add_byte(run, clvr_pkg::RS_INSTR, 8'h28);   // 4-bit bus, two lines
      add_byte(run, clvr_pkg::RS_INSTR, 8'h0C);   // display on, cursor off
      add_byte(run, clvr_pkg::RS_INSTR, 8'h06);   // entry mode, increment
      add_byte(run, clvr_pkg::RS_INSTR, 8'h01);   // clear
    end else begin
      add_byte(run, clvr_pkg::RS_INSTR, 8'h80);   // first line home
      add_text(run, "ADC=");
      add_byte(run, clvr_pkg::RS_DATA, 8'h30 + 8'(value / 1000));
      add_byte(run, clvr_pkg::RS_DATA, 8'h30 + 8'((value / 100) % 10));
      add_byte(run, clvr_pkg::RS_DATA, 8'h30 + 8'((value / 10) % 10));
      add_byte(run, clvr_pkg::RS_DATA, 8'h30 + 8'(value % 10));
      add_byte(run, clvr_pkg::RS_INSTR, 8'hC0);   // second line home
      add_text(run, "LED=");
      // strict compare against the 13-bit threshold
      if ({1'b0, sample} < led_threshold) begin
        add_text(run, "ON ");
      end else begin
        add_text(run, "OFF");
      end
    end
    for (int i = 0; i < run.size(); i++) begin
      lcd_write_t w;
      w = run[i];
      w.last = (i == run.size() - 1);
      lcd_writes_due.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: pops the next request when the channel is free and the random idle draw allows it
  // prediction happens here, on the edge that accepts the transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_lcd_writes(in_command, in_sample);
        if (in_command == clvr_pkg::CMD_INIT) begin
          init_count++;
        end else begin
          show_count++;
        end
      end
      // a held transaction stays untouched until accepted
      if (!(in_valid && !in_ready)) begin
        if (request_fifo.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          lcd_request_t req;
          req = request_fifo.pop_front();
          in_valid   <= 1'b1;
          in_command <= req.command;
          in_sample  <= req.sample;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // nibble monitor: random backpressure and in-order compare
  // ---------------------------------------------------------------------------
  function automatic void note_error(input string what, input lcd_write_t want,
                                     input lcd_write_t got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("error: %s at write %0d: expected rs=%0b nib=%h last=%0b,",
               what, writes_checked, want.rs, want.nib, want.last);
      $display("       got rs=%0b nib=%h last=%0b", got.rs, got.nib, got.last);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        lcd_write_t got;
        got = '{rs: out_register_select, nib: out_nibble, last: out_last};
        if (lcd_writes_due.size() == 0) begin
          note_error("unexpected transaction", '0, got);
        end else begin
          lcd_write_t want;
          want = lcd_writes_due.pop_front();
          if (got !== want) begin
            note_error("mismatch", want, got);
          end
        end
        writes_checked++;
      end
      out_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_threshold(input logic [clvr_pkg::THR_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    // the access phase completes on this edge since pready is tied high
    @(posedge clk);
    led_threshold = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // wait until every request is out and every expected write has arrived
  task automatic wait_drained();
    while (request_fifo.size() != 0 || in_valid || lcd_writes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  function automatic void queue_request(input logic command, input logic [11:0] sample);
    request_fifo.push_back('{command: command, sample: sample});
  endfunction

  // samples biased toward the extremes, digit rollovers and the threshold edge
  function automatic logic [11:0] pick_sample();
    int kind;
    int val;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        val = $urandom_range(1) ? 4095 : 0;
      end
      1, 2: begin
        val = int'(led_threshold) + $urandom_range(3) - 2;
        if (val < 0) val = 0;
        if (val > 4095) val = 4095;
      end
      3: begin
        // values on a decimal carry boundary, like x999 or x000
        val = $urandom_range(4) * 1000 + $urandom_range(9) * 100 +
              ($urandom_range(1) ? 99 : 0);
        if (val > 4095) val = 4095;
      end
      default: begin
        val = $urandom_range(4095);
      end
    endcase
    return 12'(val);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the reset threshold of 2000, no idling
    queue_request(clvr_pkg::CMD_INIT, 12'hFFF);
    queue_request(clvr_pkg::CMD_SHOW, 12'd0);
    queue_request(clvr_pkg::CMD_SHOW, 12'd4095);
    queue_request(clvr_pkg::CMD_SHOW, 12'd1999);
    queue_request(clvr_pkg::CMD_SHOW, 12'd2000);
    queue_request(clvr_pkg::CMD_SHOW, 12'd2001);
    queue_request(clvr_pkg::CMD_INIT, 12'd0);
    queue_request(clvr_pkg::CMD_SHOW, 12'd999);
    queue_request(clvr_pkg::CMD_SHOW, 12'd1000);
    queue_request(clvr_pkg::CMD_SHOW, 12'd9);
    queue_request(clvr_pkg::CMD_SHOW, 12'd10);
    queue_request(clvr_pkg::CMD_SHOW, 12'd99);
    queue_request(clvr_pkg::CMD_SHOW, 12'd100);
    queue_request(clvr_pkg::CMD_SHOW, 12'd1234);
    queue_request(clvr_pkg::CMD_SHOW, 12'd3210);
    queue_request(clvr_pkg::CMD_SHOW, 12'd4000);
    queue_request(clvr_pkg::CMD_SHOW, 12'hAAA);
    queue_request(clvr_pkg::CMD_SHOW, 12'h555);
    queue_request(clvr_pkg::CMD_INIT, 12'h555);
    queue_request(clvr_pkg::CMD_INIT, 12'hAAA);
    queue_request(clvr_pkg::CMD_SHOW, 12'd1);
    wait_drained();

    // random phases: each one gets a new threshold and an idle pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      logic [clvr_pkg::THR_W-1:0] thr;
      case (p)
        0: thr = 13'd0;        // every sample shows off
        1: thr = 13'd4096;     // every sample shows on
        2: thr = 13'd4095;     // only the top sample shows off
        3: thr = 13'd1;
        6: thr = clvr_pkg::THRESHOLD_RESET;
        default: thr = 13'($urandom_range(4096));
      endcase
      write_threshold(thr);
      @(negedge clk);

      case (p % 4)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 82;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 82;
        end
        default: begin
          src_idle_pct = 23;
          snk_stall_pct = 23;
        end
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 15) begin
          queue_request(clvr_pkg::CMD_INIT, 12'($urandom_range(4095)));
        end else begin
          queue_request(clvr_pkg::CMD_SHOW, pick_sample());
        end
      end
      wait_drained();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    // let any stray writes show up before the verdict
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (lcd_writes_due.size() != 0) begin
      error_count++;
      $display("error: %0d expected nibble writes never arrived", lcd_writes_due.size());
    end

    $display("run covered %0d init and %0d show requests, %0d nibble writes checked",
             init_count, show_count, writes_checked);
    $display("with %0d threshold settings and four idle patterns on the two channels",
             settings_used);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #3000000;
    $display("error: watchdog expired with %0d writes outstanding", lcd_writes_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: char_lcd_value_readout_unit.f
+incdir+hdl
hdl/clvr_pkg.sv
hdl/clvr_front.sv
hdl/clvr_queue.sv
hdl/clvr_back.sv
hdl/char_lcd_value_readout_unit.sv
tb/testbench.sv
